@@ rtl/bdel_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdel_pkg
// Shared types and codes for the bounded double-ended list.
// ----------------------------------------------------------------------------
package bdel_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 6;
  localparam int IDX_W  = 6;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_INSERT_AT = 3'd4,
    OP_REMOVE_AT = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic  ins;
    logic  rem;
    idx_t  idx;
    data_t value;
  } cell_cmd_t;

endpackage

@@ rtl/bdel_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdel_ifs
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdel_in_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           operation;
  logic signed [31:0]   value;
  logic [5:0]           position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink   (input valid, input operation, input value, input position,
                  output ready);
endinterface

interface bdel_out_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic signed [31:0]   removed_value;
  logic [5:0]           element_count;
  logic                 is_empty;

  modport source (output valid, output status, output removed_value,
                  output element_count, output is_empty, input ready);
  modport sink   (input valid, input status, input removed_value,
                  input element_count, input is_empty, output ready);
endinterface

@@ rtl/bdel_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdel_cell
// One list slot: holds a value, shifts from a neighbor on insert or remove.
// ----------------------------------------------------------------------------
module bdel_cell #(
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  bdel_pkg::cell_cmd_t cmd,
  input  bdel_pkg::data_t    left_data,
  input  bdel_pkg::data_t    right_data,
  output bdel_pkg::data_t    data_q,
  output bdel_pkg::data_t    tap
);
  import bdel_pkg::*;

  localparam idx_t MY_IDX = IDX_W'(INDEX);

  data_t data_r;
  data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (MY_IDX == cmd.idx) begin
        data_nxt = cmd.value;
      end else if (MY_IDX > cmd.idx) begin
        data_nxt = left_data;
      end
    end else if (cmd.rem) begin
      if (MY_IDX >= cmd.idx) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
  assign tap    = (MY_IDX == cmd.idx) ? data_r : '0;

endmodule

@@ rtl/bdel_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdel_ctrl
// Decodes each request, tracks the count, drives the cell row and the result.
// ----------------------------------------------------------------------------
module bdel_ctrl #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  bdel_in_if.sink             in_ch,
  bdel_out_if.source          out_ch,
  input  bdel_pkg::data_t     removed_tap,
  output bdel_pkg::cell_cmd_t cmd
);
  import bdel_pkg::*;

  localparam int HW = $clog2(DEPTH + 1);

  logic [HW-1:0] held_r;
  logic [HW-1:0] held_nxt;
  logic          out_valid_r;
  status_t       status_r;
  data_t         removed_r;
  cnt_t          count_r;
  logic          empty_r;

  logic          acc;
  logic          full;
  logic          empty;
  logic [6:0]    held_ext;
  logic [6:0]    pos_ext;
  logic          ins;
  logic          rem;
  idx_t          idx;
  status_t       status_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  assign full     = (held_r == HW'(DEPTH));
  assign empty    = (held_r == '0);
  assign held_ext = 7'(held_r);
  assign pos_ext  = {1'b0, in_ch.position};

  always_comb begin
    status_nxt = ST_OK;
    ins        = 1'b0;
    rem        = 1'b0;
    idx        = '0;
    unique case (op_t'(in_ch.operation))
      OP_ADD_FRONT: begin
        if (full) status_nxt = ST_FULL;
        else ins = 1'b1;
      end
      OP_ADD_BACK: begin
        if (full) status_nxt = ST_FULL;
        else begin
          ins = 1'b1;
          idx = IDX_W'(held_r);
        end
      end
      OP_REM_FRONT: begin
        if (empty) status_nxt = ST_EMPTY;
        else rem = 1'b1;
      end
      OP_REM_BACK: begin
        if (empty) status_nxt = ST_EMPTY;
        else begin
          rem = 1'b1;
          idx = IDX_W'(held_r - HW'(1));
        end
      end
      OP_INSERT_AT: begin
        if (full) status_nxt = ST_FULL;
        else if (pos_ext == 7'd0 || pos_ext > held_ext + 7'd1) status_nxt = ST_BADPOS;
        else begin
          ins = 1'b1;
          idx = IDX_W'(in_ch.position - POS_W'(1));
        end
      end
      OP_REMOVE_AT: begin
        if (empty) status_nxt = ST_EMPTY;
        else if (pos_ext == 7'd0 || pos_ext > held_ext) status_nxt = ST_BADPOS;
        else begin
          rem = 1'b1;
          idx = IDX_W'(in_ch.position - POS_W'(1));
        end
      end
      default: status_nxt = ST_BADPOS;
    endcase
  end

  assign cmd.ins   = ins && acc;
  assign cmd.rem   = rem && acc;
  assign cmd.idx   = idx;
  assign cmd.value = in_ch.value;

  always_comb begin
    held_nxt = held_r;
    if (ins) held_nxt = held_r + HW'(1);
    else if (rem) held_nxt = held_r - HW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r  <= status_nxt;
      removed_r <= rem ? removed_tap : '0;
      count_r   <= CNT_W'(held_nxt);
      empty_r   <= (held_nxt == '0);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.removed_value = removed_r;
  assign out_ch.element_count = count_r;
  assign out_ch.is_empty      = empty_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HW'(DEPTH))
    else $error("count exceeds depth");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
    acc && status_nxt == ST_FULL |-> held_r == HW'(DEPTH))
    else $error("full reported below depth");

  a_error_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && status_nxt != ST_OK |=> $stable(held_r))
    else $error("count moved on failed operation");

  a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("no result after transaction");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> count_r == CNT_W'(held_r))
    else $error("reported count differs from held count");

endmodule

@@ rtl/bounded_double_ended_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_list
// Ordered list of up to DEPTH signed words with front, back and positional
// insert and remove, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// For each accepted request, the cells from the target slot upward shift by one
// slot in the cycle the request is accepted, and the result is registered and
// shown the next cycle. A new request is taken every cycle while the result
// register is free or being drained, so throughput is one transaction per
// clock. Cells beyond the element count hold stale data and are never read.
module bounded_double_ended_list #(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bdel_in_if.sink    in_ch,
  bdel_out_if.source out_ch
);
  import bdel_pkg::*;

  cell_cmd_t cmd;
  data_t     cell_q [DEPTH];
  data_t     cell_tap [DEPTH];
  data_t     removed_tap;

  bdel_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .removed_tap (removed_tap),
    .cmd         (cmd)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left_d;
    data_t right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    bdel_cell #(.INDEX(i)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data_q     (cell_q[i]),
      .tap        (cell_tap[i])
    );
  end

  always_comb begin
    removed_tap = '0;
    for (int k = 0; k < DEPTH; k++) begin
      removed_tap = removed_tap | cell_tap[k];
    end
  end

endmodule

@@ tb/bounded_double_ended_list_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_list_tb
// Sends list operations over the request channel with random gaps and result
// back-pressure. A shadow copy of the list predicts every result, and each
// result transaction is checked field by field, in order.
// ----------------------------------------------------------------------------
module bounded_double_ended_list_tb;
  import bdel_pkg::*;

  localparam int DEPTH        = 32;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 510;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef enum int {TRAFFIC_GROW, TRAFFIC_SHRINK, TRAFFIC_MIXED} traffic_mode_t;

  typedef struct {
    status_t status;
    data_t   removed_value;
    cnt_t    element_count;
    logic    is_empty;
  } list_result_t;

  logic clk;
  logic rst_n;

  bdel_in_if  in_ch ();
  bdel_out_if out_ch ();

  bounded_double_ended_list #(.DEPTH(DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  data_t        shadow_list [DEPTH];
  int           shadow_len = 0;
  list_result_t expected_results [$];
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           no_idle = 1'b0;
  bit           hold_results = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic list_result_t predict_list_op(logic [OP_W-1:0] op, data_t val,
                                                   pos_t pos);
    list_result_t r;
    int           idx;
    int           i;
    bit           do_put;
    bit           do_take;
    r.status        = ST_OK;
    r.removed_value = '0;
    idx     = 0;
    do_put  = 1'b0;
    do_take = 1'b0;
    case (op)
      OP_ADD_FRONT, OP_ADD_BACK: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          do_put = 1'b1;
          idx    = (op == OP_ADD_FRONT) ? 0 : shadow_len;
        end
      end
      OP_REM_FRONT, OP_REM_BACK: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          do_take = 1'b1;
          idx     = (op == OP_REM_FRONT) ? 0 : shadow_len - 1;
        end
      end
      OP_INSERT_AT: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (pos < 1 || int'(pos) > shadow_len + 1) begin
          r.status = ST_BADPOS;
        end else begin
          do_put = 1'b1;
          idx    = int'(pos) - 1;
        end
      end
      OP_REMOVE_AT: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (pos < 1 || int'(pos) > shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          do_take = 1'b1;
          idx     = int'(pos) - 1;
        end
      end
      default: r.status = ST_BADPOS;
    endcase
    if (do_put) begin
      for (i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i-1];
      shadow_list[idx] = val;
      shadow_len++;
    end
    if (do_take) begin
      r.removed_value = shadow_list[idx];
      for (i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
      shadow_len--;
    end
    r.element_count = cnt_t'(shadow_len);
    r.is_empty      = (shadow_len == 0);
    return r;
  endfunction

  task automatic note_mismatch(string field, longint exp_v, longint act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(
          predict_list_op(in_ch.operation, in_ch.value, in_ch.position));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result transaction with nothing pending", $time);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status)
            note_mismatch("status", want.status, out_ch.status);
          if (out_ch.removed_value !== want.removed_value)
            note_mismatch("removed_value", want.removed_value, out_ch.removed_value);
          if (out_ch.element_count !== want.element_count)
            note_mismatch("element_count", want.element_count, out_ch.element_count);
          if (out_ch.is_empty !== want.is_empty)
            note_mismatch("is_empty", want.is_empty, out_ch.is_empty);
        end
      end
    end
  end

  initial begin : result_drain
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        gap          = HOLD_CYCLES;
        hold_results = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_request(logic [OP_W-1:0] op, data_t val, pos_t pos);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= val;
    in_ch.position  <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(OP_REM_FRONT, $urandom, pos_t'($urandom));
    send_request(OP_REM_BACK, $urandom, pos_t'($urandom));
    send_request(OP_REMOVE_AT, $urandom, 6'd0);
    send_request(OP_REMOVE_AT, $urandom, 6'd63);
    send_request(OP_INSERT_AT, $urandom, 6'd0);
    send_request(OP_INSERT_AT, $urandom, 6'd2);
    send_request(OP_INSERT_AT, 32'sh7fff_ffff, 6'd1);
    send_request(OP_ADD_FRONT, 32'sh8000_0000, pos_t'($urandom));
    send_request(OP_ADD_BACK, -32'sd1, pos_t'($urandom));
    send_request(OP_ADD_FRONT, 32'sd0, 6'd63);
    send_request(OP_INSERT_AT, 32'sh5555_5555, 6'd5);
    send_request(OP_INSERT_AT, $urandom, 6'd7);
    send_request(OP_INSERT_AT, $urandom, 6'd63);
    send_request(OP_INSERT_AT, 32'shaaaa_aaaa, 6'd3);
    send_request(OP_SPARE_6, $urandom, 6'd1);
    send_request(OP_SPARE_7, $urandom, 6'd2);
    send_request(OP_REMOVE_AT, $urandom, 6'd0);
    send_request(OP_REMOVE_AT, $urandom, 6'd7);
    send_request(OP_REMOVE_AT, $urandom, 6'd6);
    send_request(OP_REMOVE_AT, $urandom, 6'd1);
    send_request(OP_REMOVE_AT, $urandom, 6'd2);
    send_request(OP_REM_FRONT, $urandom, pos_t'($urandom));
    send_request(OP_REM_BACK, $urandom, pos_t'($urandom));
    send_request(OP_REM_BACK, $urandom, pos_t'($urandom));
    send_request(OP_REM_FRONT, $urandom, pos_t'($urandom));
  endtask

  task automatic test_result_backpressure();
    int k;
    no_idle      = 1'b1;
    hold_results = 1'b1;
    for (k = 0; k < 16; k++) begin
      if (k < 12)
        send_request(k[0] ? OP_ADD_BACK : OP_ADD_FRONT, $urandom, pos_t'($urandom));
      else
        send_request(OP_REMOVE_AT, $urandom, pos_t'($urandom_range(1, shadow_len)));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic(int n_items);
    traffic_mode_t   mode;
    int              phase_left;
    int              add_pct;
    int              pick;
    int              k;
    logic [OP_W-1:0] op;
    pos_t            pos;
    phase_left = 0;
    mode       = TRAFFIC_MIXED;
    for (k = 0; k < n_items; k++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       mode = TRAFFIC_GROW;
          1:       mode = TRAFFIC_SHRINK;
          default: mode = TRAFFIC_MIXED;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      case (mode)
        TRAFFIC_GROW:   add_pct = 80;
        TRAFFIC_SHRINK: add_pct = 20;
        default:        add_pct = 50;
      endcase
      pick = $urandom_range(0, 99);
      pos  = pos_t'($urandom);
      if (pick < 3) begin
        op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
      end else if ($urandom_range(0, 99) < add_pct) begin
        case ($urandom_range(0, 2))
          0:       op = OP_ADD_FRONT;
          1:       op = OP_ADD_BACK;
          default: op = OP_INSERT_AT;
        endcase
        if (op == OP_INSERT_AT && $urandom_range(0, 99) < 85)
          pos = pos_t'($urandom_range(1, (shadow_len < 63) ? shadow_len + 1 : 63));
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_REM_FRONT;
          1:       op = OP_REM_BACK;
          default: op = OP_REMOVE_AT;
        endcase
        if (op == OP_REMOVE_AT && shadow_len > 0 && $urandom_range(0, 99) < 85)
          pos = pos_t'($urandom_range(1, shadow_len));
      end
      send_request(op, $urandom, pos);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.value     = '0;
    in_ch.position  = '0;
    rst_n           = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_traffic(RANDOM_ITEMS / 2);
    test_result_backpressure();
    test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
